FILE: rtl/e2p_pkg.sv
// e2p_pkg: shared widths, register indexes and the CORDIC arctangent table
// for the equirectangular-to-perspective remap unit. No dependencies.
`timescale 1ns / 1ps

package e2p_pkg;

  // Field widths
  localparam int IN_W   = 12;  // out_col / out_row
  localparam int COL_W  = 12;  // src_col
  localparam int ROW_W  = 11;  // src_row
  localparam int DIM_W  = 13;  // out_width / out_height
  localparam int CFG_W  = 16;  // widest register
  localparam int COEF_W = 16;  // Q2.14 cos/sin
  localparam int FOC_W  = 16;  // Q8.8 focal
  localparam int IDX_W  = 3;   // register index

  // Register indexes
  localparam logic [IDX_W-1:0] REG_HEAD_COS  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEAD_SIN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PITCH_COS = 3'd2;
  localparam logic [IDX_W-1:0] REG_PITCH_SIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_FOCAL     = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUT_W     = 3'd5;
  localparam logic [IDX_W-1:0] REG_OUT_H     = 3'd6;

  // Datapath widths
  localparam int FRAC_W = 14;  // Q14 plane coordinates
  localparam int YZ_W   = 28;  // signed y, z
  localparam int XR_W   = 32;  // signed rotated x, y
  localparam int ZR_W   = 30;  // signed rotated z
  localparam int CW     = 34;  // CORDIC x/y datapath
  localparam int ANG_W  = 34;  // CORDIC angle, pi = 2^31

  localparam logic [16:0] GAIN_INV = 17'd39797;

  // atan(2^-i) with pi = 2^31
  localparam logic [31:0] ATAN_TAB [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

FILE: rtl/e2p_if.sv
// e2p_if: valid/ready channel interfaces for pixel coordinates in and
// source coordinates out. Depends on e2p_pkg.
`timescale 1ns / 1ps

interface e2p_in_if import e2p_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IN_W-1:0]  out_col;
  logic [IN_W-1:0]  out_row;

  modport source (output valid, output out_col, output out_row, input ready);
  modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

interface e2p_out_if import e2p_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] src_col;
  logic [ROW_W-1:0] src_row;
  logic             valid_res;

  modport source (output valid, output src_col, output src_row, output valid_res,
                  input ready);
  modport sink   (input valid, input src_col, input src_row, input valid_res,
                  output ready);
endinterface

FILE: rtl/e2p_ndiv.sv
// e2p_ndiv: pipelined restoring divider for one plane coordinate,
// (dim - 2*pos) * 2^14 / dim truncated toward zero. Depends on e2p_pkg.
`timescale 1ns / 1ps

module e2p_ndiv import e2p_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic [IN_W-1:0]        pos_i,
  input  logic [DIM_W-1:0]       dim_i,
  output logic                   vld_o,
  output logic signed [YZ_W-1:0] q_o
);

  localparam int NB = DIM_W + FRAC_W;

  logic [NB:0]          vld_r;
  logic [NB:0]          neg_r;
  logic [NB-1:0]        nq_r  [0:NB];
  logic [DIM_W-1:0]     rem_r [0:NB];
  logic                 q_vld_r;
  logic signed [YZ_W-1:0] q_r;

  logic signed [DIM_W+1:0] diff;
  logic signed [DIM_W+1:0] diff_neg;
  logic [DIM_W-1:0]        mag;

  // Signed numerator magnitude
  assign diff     = $signed({2'b00, dim_i}) - $signed({2'b00, pos_i, 1'b0});
  assign diff_neg = -diff;
  assign mag      = diff[DIM_W+1] ? diff_neg[DIM_W-1:0] : diff[DIM_W-1:0];

  // Valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[NB-1:0], vld_i};
      q_vld_r <= vld_r[NB];
    end
  end

  // Load stage
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= diff[DIM_W+1];
      nq_r[0]  <= {mag, {FRAC_W{1'b0}}};
      rem_r[0] <= '0;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < NB; k++) begin : g_bit
    logic [DIM_W:0]   trial;
    logic [DIM_W:0]   sub;
    logic             ge;
    logic [DIM_W-1:0] rem_nxt;

    assign trial   = {rem_r[k], nq_r[k][NB-1]};
    assign sub     = trial - {1'b0, dim_i};
    assign ge      = trial >= {1'b0, dim_i};
    assign rem_nxt = ge ? sub[DIM_W-1:0] : trial[DIM_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        nq_r[k+1]  <= {nq_r[k][NB-2:0], ge};
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  // Apply sign
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= neg_r[NB] ? -$signed({1'b0, nq_r[NB]}) : $signed({1'b0, nq_r[NB]});
    end
  end

  assign vld_o = q_vld_r;
  assign q_o   = q_r;

endmodule

FILE: rtl/e2p_rot.sv
// e2p_rot: five-stage fixed-point rotation of the ray (focal, y, z) by
// pitch and heading, wide products split into partial products. Uses e2p_pkg.
`timescale 1ns / 1ps

module e2p_rot import e2p_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic signed [YZ_W-1:0]   y_i,
  input  logic signed [YZ_W-1:0]   z_i,
  input  logic signed [COEF_W-1:0] hc_i,
  input  logic signed [COEF_W-1:0] hs_i,
  input  logic signed [COEF_W-1:0] pc_i,
  input  logic signed [COEF_W-1:0] ps_i,
  input  logic [FOC_W-1:0]         focal_i,
  output logic                     vld_o,
  output logic signed [XR_W-1:0]   xr_o,
  output logic signed [XR_W-1:0]   yr_o,
  output logic signed [ZR_W-1:0]   zr_o
);

  localparam int XF_W  = FOC_W + 7;
  localparam int PX_W  = COEF_W + XF_W;
  localparam int PZ_W  = COEF_W + YZ_W;
  localparam int A_W   = 44;
  localparam int LO_W  = 22;
  localparam int HI_W  = A_W - LO_W;
  localparam int PH_W  = COEF_W + HI_W;
  localparam int PL_W  = COEF_W + LO_W + 1;
  localparam int ZN_W  = PZ_W + 1;
  localparam int SUM_W = 62;

  logic [4:0] vld_r;

  // Stage 1
  logic signed [XF_W-1:0] x_fix;
  logic signed [PX_W-1:0] pcx_r, psx_r;
  logic signed [PZ_W-1:0] psz_r, pcz_r;
  logic signed [YZ_W-1:0] y1_r;
  // Stage 2
  logic signed [A_W-1:0]  a_r;
  logic signed [ZN_W-1:0] znum, zsh;
  logic signed [ZR_W-1:0] zr2_r, zr3_r, zr4_r, zr5_r;
  logic signed [PZ_W-1:0] hsy_r, hcy_r, hsy3_r, hcy3_r;
  // Stage 3
  logic signed [HI_W-1:0] ahi;
  logic signed [LO_W:0]   alo;
  logic signed [PH_W-1:0] hchi_r, hshi_r;
  logic signed [PL_W-1:0] hclo_r, hslo_r;
  // Stage 4
  logic signed [SUM_W-1:0] hchi_e, hshi_e, hclo_e, hslo_e, hsy_e, hcy_e;
  logic signed [SUM_W-1:0] xs_r, ys_r;
  // Stage 5
  logic signed [SUM_W-1:0] xsh, ysh;
  logic signed [XR_W-1:0]  xr_r, yr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  // Stage 1: first products of the pitch rotation
  assign x_fix = $signed({1'b0, focal_i, 6'b000000});

  always_ff @(posedge clk) begin
    if (en) begin
      pcx_r <= pc_i * x_fix;
      psx_r <= ps_i * x_fix;
      psz_r <= ps_i * z_i;
      pcz_r <= pc_i * z_i;
      y1_r  <= y_i;
    end
  end

  // Stage 2: finish pitch, start heading on y
  assign znum = pcz_r - psx_r;
  assign zsh  = (znum + $signed({{(ZN_W-FRAC_W){1'b0}}, {FRAC_W{znum[ZN_W-1]}}}))
                >>> FRAC_W;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= pcx_r + psz_r;
      zr2_r <= zsh[ZR_W-1:0];
      hsy_r <= hs_i * y1_r;
      hcy_r <= hc_i * y1_r;
    end
  end

  // Stage 3: split the wide pitch result into partial products
  assign ahi = a_r[A_W-1:LO_W];
  assign alo = $signed({1'b0, a_r[LO_W-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      hchi_r <= hc_i * ahi;
      hshi_r <= hs_i * ahi;
      hclo_r <= hc_i * alo;
      hslo_r <= hs_i * alo;
      hsy3_r <= hsy_r;
      hcy3_r <= hcy_r;
      zr3_r  <= zr2_r;
    end
  end

  // Stage 4: combine partial products
  assign hchi_e = hchi_r;
  assign hshi_e = hshi_r;
  assign hclo_e = hclo_r;
  assign hslo_e = hslo_r;
  assign hsy_e  = hsy3_r;
  assign hcy_e  = hcy3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r  <= (hchi_e <<< LO_W) + hclo_e - (hsy_e <<< FRAC_W);
      ys_r  <= (hshi_e <<< LO_W) + hslo_e + (hcy_e <<< FRAC_W);
      zr4_r <= zr3_r;
    end
  end

  // Stage 5: drop to Q14, truncating toward zero
  assign xsh = (xs_r + $signed({{(SUM_W-2*FRAC_W){1'b0}}, {(2*FRAC_W){xs_r[SUM_W-1]}}}))
               >>> (2*FRAC_W);
  assign ysh = (ys_r + $signed({{(SUM_W-2*FRAC_W){1'b0}}, {(2*FRAC_W){ys_r[SUM_W-1]}}}))
               >>> (2*FRAC_W);

  always_ff @(posedge clk) begin
    if (en) begin
      xr_r  <= xsh[XR_W-1:0];
      yr_r  <= ysh[XR_W-1:0];
      zr5_r <= zr4_r;
    end
  end

  assign vld_o = vld_r[4];
  assign xr_o  = xr_r;
  assign yr_o  = yr_r;
  assign zr_o  = zr5_r;

endmodule

FILE: rtl/e2p_cordic.sv
// e2p_cordic: pipelined vectoring CORDIC, one iteration per stage, with a
// quadrant pre-rotation stage and a sideband carried along. Uses e2p_pkg.
`timescale 1ns / 1ps

module e2p_cordic import e2p_pkg::*; #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic signed [CW-1:0]    x_i,
  input  logic signed [CW-1:0]    y_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    vld_o,
  output logic signed [ANG_W-1:0] ang_o,
  output logic signed [CW-1:0]    mag_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam logic signed [ANG_W-1:0] ANG_PI = ANG_W'(64'sd2147483648);

  logic [STEPS:0]          vld_r;
  logic signed [CW-1:0]    x_r    [0:STEPS];
  logic signed [CW-1:0]    y_r    [0:STEPS];
  logic signed [ANG_W-1:0] z_r    [0:STEPS];
  logic [SIDE_W-1:0]       side_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-1:0], vld_i};
    end
  end

  // Pre-rotate by pi into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      if (x_i[CW-1]) begin
        x_r[0] <= -x_i;
        y_r[0] <= -y_i;
        z_r[0] <= y_i[CW-1] ? -ANG_PI : ANG_PI;
      end else begin
        x_r[0] <= x_i;
        y_r[0] <= y_i;
        z_r[0] <= '0;
      end
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0]    dx, dy;
    logic signed [ANG_W-1:0] da;
    logic                    up;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign da = $signed({{(ANG_W-32){1'b0}}, ATAN_TAB[i]});
    assign up = !y_r[i][CW-1] && (y_r[i] != '0);

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= side_r[i];
        if (up) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + da;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - da;
        end
      end
    end
  end

  assign vld_o  = vld_r[STEPS];
  assign ang_o  = z_r[STEPS];
  assign mag_o  = x_r[STEPS];
  assign side_o = side_r[STEPS];

endmodule

FILE: rtl/equirect_to_perspective_remap_unit.sv
// Equirectangular-to-perspective remap unit: maps a perspective pixel to
// its equirectangular source column and row. Uses e2p_pkg, e2p_if,
// e2p_ndiv, e2p_rot and e2p_cordic.
// Pipeline: 29 divider stages, 5 rotation stages, two CORDIC pipelines of
// CORDIC_STEPS+1 stages and 4 more stages between and after them.
// Throughput: one pixel per cycle; a stalled output freezes the whole pipe.
// Reset (synchronous, rst_n low) clears all valid bits and loads registers.
`timescale 1ns / 1ps

module equirect_to_perspective_remap_unit import e2p_pkg::*; #(
  parameter int SRC_WIDTH    = 4096,
  parameter int SRC_HEIGHT   = 2048,
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  e2p_in_if.sink           in_ch,
  e2p_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic signed [13:0] SRC_W_S = 14'(SRC_WIDTH);
  localparam logic signed [12:0] SRC_H_S = 13'(SRC_HEIGHT);
  localparam int MAGP_W = CW + 18;
  localparam int COLP_W = ANG_W + 14;
  localparam int ROWP_W = ANG_W + 13;

  // Configuration registers
  logic signed [COEF_W-1:0] hc_r, hs_r, pc_r, ps_r;
  logic [FOC_W-1:0]         focal_r;
  logic [DIM_W-1:0]         ow_r, oh_r;
  logic [DIM_W-1:0]         w_eff, h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r    <= 16'sd16384;
      hs_r    <= '0;
      pc_r    <= 16'sd16384;
      ps_r    <= '0;
      focal_r <= 16'd256;
      ow_r    <= 13'd1024;
      oh_r    <= 13'd1024;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HEAD_COS:  hc_r    <= cfg_wdata;
        REG_HEAD_SIN:  hs_r    <= cfg_wdata;
        REG_PITCH_COS: pc_r    <= cfg_wdata;
        REG_PITCH_SIN: ps_r    <= cfg_wdata;
        REG_FOCAL:     focal_r <= cfg_wdata;
        REG_OUT_W:     ow_r    <= cfg_wdata[DIM_W-1:0];
        REG_OUT_H:     oh_r    <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Treat a zero view size as one
  assign w_eff = (ow_r == '0) ? DIM_W'(1) : ow_r;
  assign h_eff = (oh_r == '0) ? DIM_W'(1) : oh_r;

  // Whole pipe advances unless the output register holds an untaken result
  logic out_vld_r;
  logic en;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Plane coordinates
  logic                   dy_vld, dz_vld;
  logic signed [YZ_W-1:0] y_q, z_q;

  e2p_ndiv u_div_y (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_ch.valid),
    .pos_i(in_ch.out_col), .dim_i(w_eff), .vld_o(dy_vld), .q_o(y_q)
  );

  e2p_ndiv u_div_z (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_ch.valid),
    .pos_i(in_ch.out_row), .dim_i(h_eff), .vld_o(dz_vld), .q_o(z_q)
  );

  // Ray rotation
  logic                   rot_vld;
  logic signed [XR_W-1:0] xr, yr;
  logic signed [ZR_W-1:0] zr;

  e2p_rot u_rot (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(dy_vld && dz_vld),
    .y_i(y_q), .z_i(z_q), .hc_i(hc_r), .hs_i(hs_r), .pc_i(pc_r), .ps_i(ps_r),
    .focal_i(focal_r), .vld_o(rot_vld), .xr_o(xr), .yr_o(yr), .zr_o(zr)
  );

  // Azimuth CORDIC, rotated z rides along
  logic                    c1_vld;
  logic signed [ANG_W-1:0] theta;
  logic signed [CW-1:0]    c1_mag;
  logic [ZR_W-1:0]         c1_zr;

  e2p_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(ZR_W)) u_cordic_az (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(rot_vld),
    .x_i(CW'(yr)), .y_i(CW'(xr)), .side_i(zr),
    .vld_o(c1_vld), .ang_o(theta), .mag_o(c1_mag), .side_o(c1_zr)
  );

  // Mid stage 1: gain correction and column products
  logic                     m1_vld_r, m2_vld_r;
  logic signed [MAGP_W-1:0] magp_r;
  logic signed [COLP_W-1:0] colp_r;
  logic [ZR_W-1:0]          zr_m1_r, zr_m2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      magp_r  <= c1_mag * $signed({1'b0, GAIN_INV});
      colp_r  <= theta * SRC_W_S;
      zr_m1_r <= c1_zr;
    end
  end

  // Mid stage 2: truncate toward zero, wrap the column
  logic signed [MAGP_W-1:0] magsh;
  logic signed [COLP_W-1:0] colsh;
  logic signed [15:0]       scf, scw;
  logic signed [CW-1:0]     mag_r;
  logic [COL_W-1:0]         sc_r;

  assign magsh = (magp_r + $signed({{(MAGP_W-16){1'b0}}, {16{magp_r[MAGP_W-1]}}})) >>> 16;
  assign colsh = (colp_r + $signed({{(COLP_W-32){1'b0}}, {32{colp_r[COLP_W-1]}}})) >>> 32;
  assign scf   = colsh[15:0];
  assign scw   = scf[15] ? (scf + 16'(SRC_WIDTH)) : scf;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= magsh[CW-1:0];
      sc_r    <= scw[COL_W-1:0];
      zr_m2_r <= zr_m1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= c1_vld;
      m2_vld_r <= m1_vld_r;
    end
  end

  // Polar CORDIC, wrapped column rides along
  logic                    c2_vld;
  logic signed [ANG_W-1:0] phi;
  logic [COL_W-1:0]        c2_sc;
  logic signed [ZR_W-1:0]  zr_s;

  assign zr_s = zr_m2_r;

  e2p_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(COL_W)) u_cordic_pol (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(m2_vld_r),
    .x_i(CW'(zr_s)), .y_i(mag_r), .side_i(sc_r),
    .vld_o(c2_vld), .ang_o(phi), .mag_o(), .side_o(c2_sc)
  );

  // Final stage 1: row product
  logic                     f1_vld_r;
  logic signed [ROWP_W-1:0] rowp_r;
  logic [COL_W-1:0]         sc_f1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rowp_r  <= phi * SRC_H_S;
      sc_f1_r <= c2_sc;
    end
  end

  // Final stage 2: row truncation, range check, output register
  logic signed [ROWP_W-1:0] rowsh;
  logic [15:0]              srf;
  logic                     row_ok;
  logic [COL_W-1:0]         src_col_r;
  logic [ROW_W-1:0]         src_row_r;
  logic                     res_r;

  assign rowsh  = (rowp_r + $signed({{(ROWP_W-31){1'b0}}, {31{rowp_r[ROWP_W-1]}}})) >>> 31;
  assign srf    = rowsh[15:0];
  assign row_ok = !srf[15] && (srf[14:0] < 15'(SRC_HEIGHT));

  always_ff @(posedge clk) begin
    if (en) begin
      src_col_r <= row_ok ? sc_f1_r : '0;
      src_row_r <= row_ok ? srf[ROW_W-1:0] : '0;
      res_r     <= row_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r  <= c2_vld;
      out_vld_r <= f1_vld_r;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.src_col   = src_col_r;
  assign out_ch.src_row   = src_row_r;
  assign out_ch.valid_res = res_r;

  // Checks
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.valid_res |-> out_ch.src_col == '0 && out_ch.src_row == '0)
    else $error("unmapped pixel carries nonzero coordinates");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> {1'b0, out_ch.src_col} < 13'(SRC_WIDTH))
    else $error("source column outside the source width");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.valid_res |-> {1'b0, out_ch.src_row} < 12'(SRC_HEIGHT))
    else $error("mapped source row outside the source height");

  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input held off without an output stall");

endmodule

FILE: verif/equirect_to_perspective_remap_unit_test.sv
// Self-checking testbench for equirect_to_perspective_remap_unit: random and
// directed pixel transfers under random stalls, checked against a predictor.
// Depends on e2p_pkg, e2p_if and the remap unit RTL.
`timescale 1ns / 1ps

module equirect_to_perspective_remap_unit_test;
  import e2p_pkg::*;

  localparam int SRC_W_T   = 4096;
  localparam int SRC_H_T   = 2048;
  localparam int STEPS_T   = 16;
  localparam int LATENCY_T = 2 * STEPS_T + 40;

  typedef struct packed {
    logic [COL_W-1:0] src_col;
    logic [ROW_W-1:0] src_row;
    logic             valid_res;
  } src_coord_t;

  // Holds the register copy, predicts source coordinates, checks results
  class remap_scoreboard;
    logic [15:0]      hcos, hsin, pcos, psin, foc;
    logic [DIM_W-1:0] view_w, view_h;
    src_coord_t       expected_q[$];
    int               mismatches;
    int               results_seen;

    function new();
      hcos = 16'd16384; hsin = 16'd0; pcos = 16'd16384; psin = 16'd0;
      foc = 16'd256; view_w = 13'd1024; view_h = 13'd1024;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_HEAD_COS:  hcos = val;
        REG_HEAD_SIN:  hsin = val;
        REG_PITCH_COS: pcos = val;
        REG_PITCH_SIN: psin = val;
        REG_FOCAL:     foc = val;
        REG_OUT_W:     view_w = val[DIM_W-1:0];
        REG_OUT_H:     view_h = val[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Vectoring arctangent, pi = 2^31, floor shifts
    function longint vec_angle(longint yv, longint xv, output longint magn);
      longint z, dx, dy;
      z = 0;
      if (xv < 0) begin
        z = (yv >= 0) ? 64'sh8000_0000 : -64'sh8000_0000;
        xv = -xv;
        yv = -yv;
      end
      for (int i = 0; i < STEPS_T; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv > 0) begin
          xv += dx; yv -= dy; z += longint'(ATAN_TAB[i]);
        end else begin
          xv -= dx; yv += dy; z -= longint'(ATAN_TAB[i]);
        end
      end
      magn = xv;
      return z;
    endfunction

    function void note_input(logic [IN_W-1:0] col, logic [IN_W-1:0] row);
      longint w, h, c, r, hc, hs, pc, ps, xx, yy, zz, a, xr, yr, zr;
      longint magn, unused_mag, theta, phi, sc, sr;
      src_coord_t e;
      c = longint'(col); r = longint'(row);
      w = (view_w == 0) ? 1 : longint'(view_w);
      h = (view_h == 0) ? 1 : longint'(view_h);
      hc = longint'($signed(hcos)); hs = longint'($signed(hsin));
      pc = longint'($signed(pcos)); ps = longint'($signed(psin));
      xx = longint'(foc) * 64;
      yy = ((w - 2 * c) * 16384) / w;
      zz = ((h - 2 * r) * 16384) / h;
      a  = pc * xx + ps * zz;
      xr = (hc * a - hs * yy * 16384) / 64'sd268435456;
      yr = (hs * a + hc * yy * 16384) / 64'sd268435456;
      zr = (pc * zz - ps * xx) / 16384;
      theta = vec_angle(xr, yr, magn);
      magn  = (magn * 39797) / 65536;
      phi   = vec_angle(magn, zr, unused_mag);
      sc = (theta * SRC_W_T) / 64'sh1_0000_0000;
      sc = sc % SRC_W_T;
      if (sc < 0) sc += SRC_W_T;
      sr = (phi * SRC_H_T) / 64'sh8000_0000;
      if (sr < 0 || sr >= SRC_H_T) begin
        e = '0;
      end else begin
        e.src_col = sc[COL_W-1:0];
        e.src_row = sr[ROW_W-1:0];
        e.valid_res = 1'b1;
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(src_coord_t got);
      src_coord_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result col=%0d row=%0d ok=%0d",
                   got.src_col, got.src_row, got.valid_res);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected col=%0d row=%0d ok=%0d, got col=%0d row=%0d ok=%0d",
                   results_seen, e.src_col, e.src_row, e.valid_res,
                   got.src_col, got.src_row, got.valid_res);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  e2p_in_if  in_ch ();
  e2p_out_if out_ch ();

  equirect_to_perspective_remap_unit #(
    .SRC_WIDTH(SRC_W_T), .SRC_HEIGHT(SRC_H_T), .CORDIC_STEPS(STEPS_T)
  ) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  remap_scoreboard sb = new();
  bit  hold_off_req;
  bit  stim_done;
  int  pixels_sent;
  int  settings_run;
  int  send_quiet_left;
  int  recv_quiet_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Pick a wait in cycles, with occasional runs of back-to-back transfers
  function automatic int draw_gap(ref int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  task automatic send_pixel(logic [IN_W-1:0] col, logic [IN_W-1:0] row);
    int gap;
    gap = draw_gap(send_quiet_left);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.out_col <= col;
    in_ch.out_row <= row;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(col, row);
    pixels_sent++;
  endtask

  // Let the pipe drain before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY_T + 8) @(posedge clk);
  endtask

  task automatic load_view(logic [15:0] hc, logic [15:0] hs, logic [15:0] pc,
                           logic [15:0] ps, logic [15:0] fc, logic [15:0] w,
                           logic [15:0] h);
    logic [CFG_W-1:0] vals [7];
    logic [IDX_W-1:0] idxs [7];
    vals = '{hc, hs, pc, ps, fc, w, h};
    idxs = '{REG_HEAD_COS, REG_HEAD_SIN, REG_PITCH_COS, REG_PITCH_SIN,
             REG_FOCAL, REG_OUT_W, REG_OUT_H};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Mostly pixels inside the view, sometimes anywhere in the field range
  task automatic random_pixels(int n);
    int w, h;
    logic [IN_W-1:0] c, r;
    w = (sb.view_w == 0) ? 1 : int'(sb.view_w);
    h = (sb.view_h == 0) ? 1 : int'(sb.view_h);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        c = IN_W'($urandom_range(0, 4095));
        r = IN_W'($urandom_range(0, 4095));
      end else begin
        c = IN_W'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
        r = IN_W'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
      end
      send_pixel(c, r);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, check each transfer
  initial begin : receiver
    int stall;
    src_coord_t got;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = draw_gap(recv_quiet_left);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.src_col   = out_ch.src_col;
      got.src_row   = out_ch.src_row;
      got.valid_res = out_ch.valid_res;
      sb.check_result(got);
    end
  end

  // Main stimulus
  initial begin : stimulus
    in_ch.valid   <= 1'b0;
    in_ch.out_col <= '0;
    in_ch.out_row <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset view: corners, center, pixels past the view edge
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd1023, 12'd0);
    send_pixel(12'd0, 12'd1023);
    send_pixel(12'd2048, 12'd3000);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    random_pixels(60);
    drain();

    // Negative cos and positive sin extremes, widest view, largest focal
    load_view(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 16'd65535,
              16'd4096, 16'd4096);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2048, 12'd2048);
    random_pixels(90);
    drain();

    // Smallest nonzero focal, one-pixel view, zero size treated as one
    load_view(16'sd16384, -16'sd16384, 16'sd0, -16'sd16384, 16'd1, 16'd1, 16'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    random_pixels(60);
    drain();

    // Zero ray: focal zero at the view center, then zero pitch pair
    load_view(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'd0, 16'd2, 16'd2);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd0, 12'd0);
    drain();
    load_view(16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 16'd256, 16'd0, 16'd64);
    send_pixel(12'd0, 12'd32);
    random_pixels(40);
    drain();

    // Random views, including inconsistent cos/sin pairs; one long receiver hold
    for (int p = 0; p < 6; p++) begin
      load_view(16'($urandom_range(0, 32768) - 16384),
                16'($urandom_range(0, 32768) - 16384),
                16'($urandom_range(0, 32768) - 16384),
                16'($urandom_range(0, 32768) - 16384),
                16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4096)),
                16'($urandom_range(1, 4096)));
      if (p == 1) hold_off_req = 1'b1;
      random_pixels(90);
      drain();
    end
    stim_done = 1'b1;
  end

  // Final report
  initial begin : report
    wait (stim_done);
    $display("Covered %0d pixels over %0d register settings, %0d results checked.",
             pixels_sent, settings_run, sb.results_seen);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, results still owed: %0d",
               sb.mismatches, sb.expected_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d results still owed", sb.expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: equirect_to_perspective_remap_unit.f
rtl/e2p_pkg.sv
rtl/e2p_if.sv
rtl/e2p_ndiv.sv
rtl/e2p_rot.sv
rtl/e2p_cordic.sv
rtl/equirect_to_perspective_remap_unit.sv
verif/equirect_to_perspective_remap_unit_test.sv
